// ----- hdl/fadt_pkg.sv -----
// fadt_pkg: shared types, codes and constants of the flow aging delta tracker
// depends on nothing; used by fadt_ctrl, fadt_dp and flow_aging_delta_tracker
`default_nettype none

package fadt_pkg;

    localparam int FLOW_SLOTS_DEF = 1024;
    localparam int TO_W           = 24;
    localparam int NS_W           = 30;
    localparam int LIMIT_W        = TO_W + NS_W;

    localparam logic [NS_W-1:0] NS_PER_S = 30'd1000000000;

    localparam logic [7:0] PROTO_ICMP  = 8'd1;
    localparam logic [7:0] PROTO_TCP   = 8'd6;
    localparam logic [7:0] PROTO_UDP   = 8'd17;
    localparam logic [7:0] PROTO_ICMP6 = 8'd58;

    localparam logic [TO_W-1:0] TCP_TO_RST  = 24'd7440;
    localparam logic [TO_W-1:0] UDP_TO_RST  = 24'd180;
    localparam logic [TO_W-1:0] ICMP_TO_RST = 24'd30;
    localparam logic [TO_W-1:0] GEN_TO_RST  = 24'd600;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_START  = 2'd1,
        OP_END    = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_ACTIVE  = 2'd0,
        KIND_EXPIRED = 2'd1,
        KIND_SUMMARY = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_TCP_TO  = 2'd0,
        REG_UDP_TO  = 2'd1,
        REG_ICMP_TO = 2'd2,
        REG_GEN_TO  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [9:0]  flow_slot;
        logic [7:0]  protocol;
        logic [62:0] packet_count;
        logic [62:0] byte_count;
        logic [63:0] last_seen_ns;
        logic [63:0] pass_time_ns;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [9:0]  out_slot;
        logic [7:0]  out_protocol;
        logic [62:0] out_packets;
        logic [62:0] out_bytes;
        logic [63:0] out_last_seen_ns;
        logic [62:0] delta_packets;
        logic [62:0] delta_bytes;
        logic [31:0] active_total;
        logic [31:0] expired_total;
        logic [31:0] walked_total;
    } out_item_t;

    typedef struct packed {
        logic [62:0] pk;
        logic [62:0] by;
        logic [63:0] ls;
    } prev_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_CLEAR,
        ST_PRUNE,
        ST_SUMMARY
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic clear_counters;
        logic clear_seen;
        logic clear_valid;
        logic prune_rd;
        logic prune_wr;
        logic commit;
        logic emit_sum;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       slot_ok;
        logic       out_free;
    } stat_t;

endpackage

`default_nettype wire

// ----- hdl/flow_aging_delta_tracker.sv -----
// flow_aging_delta_tracker: top level, joins sequencer and datapath
// depends on fadt_pkg, fadt_ctrl, fadt_dp
//
//  channel | direction | handshake               | beat
//  in      | in        | in_valid / in_stall     | fadt_pkg::in_item_t
//  out     | out       | out_valid / out_stall   | fadt_pkg::out_item_t
//  cfg     | in        | cfg_wr_en               | cfg_index, cfg_data
//
// a flow record steps through accept, memory read, then evaluate and write back;
//   the read step serves the registered read of the tracker memories
// start pass: accept, then a sweep that clears one seen mark per cycle
// end pass: accept, the prune sweep, whose write back trails its registered read,
//   then the summary beat
// after reset a clearing pass over all FLOW_SLOTS slots runs with in_stall high
// a result waits in the output register; the next beat is accepted meanwhile,
//   and a record's evaluation or the summary beat waits until the held one leaves
`default_nettype none

module flow_aging_delta_tracker #(
    parameter int FLOW_SLOTS = fadt_pkg::FLOW_SLOTS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [23:0]         cfg_data,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire fadt_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output fadt_pkg::out_item_t      out_data
);

    localparam int IDX_W = $clog2(FLOW_SLOTS);

    // command and status between sequencer and datapath
    fadt_pkg::cmd_t   cmd;
    fadt_pkg::stat_t  stat;
    logic [IDX_W-1:0] sweep_addr;
    logic [IDX_W-1:0] prune_addr;

    fadt_ctrl #(
        .FLOW_SLOTS (FLOW_SLOTS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .stat       (stat),
        .cmd        (cmd),
        .sweep_addr (sweep_addr),
        .prune_addr (prune_addr)
    );

    fadt_dp #(
        .FLOW_SLOTS (FLOW_SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_data    (in_data),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_data   (out_data),
        .cmd        (cmd),
        .sweep_addr (sweep_addr),
        .prune_addr (prune_addr),
        .stat       (stat)
    );

endmodule

`default_nettype wire

// ----- hdl/fadt_ctrl.sv -----
// fadt_ctrl: sequencer of the tracker (record steps, clear and prune sweeps)
// depends on fadt_pkg
`default_nettype none

module fadt_ctrl #(
    parameter int FLOW_SLOTS = fadt_pkg::FLOW_SLOTS_DEF,
    parameter int IDX_W      = $clog2(FLOW_SLOTS),
    parameter int CNT_W      = $clog2(FLOW_SLOTS + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire fadt_pkg::stat_t  stat,
    output fadt_pkg::cmd_t        cmd,
    output logic [IDX_W-1:0]      sweep_addr,
    output logic [IDX_W-1:0]      prune_addr
);

    localparam logic [CNT_W-1:0] LAST = CNT_W'(FLOW_SLOTS - 1);
    localparam logic [CNT_W-1:0] ENDC = CNT_W'(FLOW_SLOTS);

    fadt_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] cnt_m1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fadt_pkg::ST_INIT:
            begin
                if (cnt_reg == LAST)
                    state_next = fadt_pkg::ST_IDLE;
            end
            fadt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (stat.op == fadt_pkg::OP_RECORD && stat.slot_ok)
                        state_next = fadt_pkg::ST_READ;
                    else if (stat.op == fadt_pkg::OP_START)
                        state_next = fadt_pkg::ST_CLEAR;
                    else if (stat.op == fadt_pkg::OP_END)
                        state_next = fadt_pkg::ST_PRUNE;
                end
            end
            fadt_pkg::ST_READ:    state_next = fadt_pkg::ST_EVAL;
            fadt_pkg::ST_EVAL:
            begin
                if (stat.out_free)
                    state_next = fadt_pkg::ST_IDLE;
            end
            fadt_pkg::ST_CLEAR:
            begin
                if (cnt_reg == LAST)
                    state_next = fadt_pkg::ST_IDLE;
            end
            fadt_pkg::ST_PRUNE:
            begin
                if (cnt_reg == ENDC)
                    state_next = fadt_pkg::ST_SUMMARY;
            end
            fadt_pkg::ST_SUMMARY:
            begin
                if (stat.out_free)
                    state_next = fadt_pkg::ST_IDLE;
            end
            default:              state_next = fadt_pkg::ST_INIT;
        endcase
    end

    always_comb
    begin
        cnt_next = '0;
        if ((state_reg == fadt_pkg::ST_INIT || state_reg == fadt_pkg::ST_CLEAR ||
             state_reg == fadt_pkg::ST_PRUNE) && state_next == state_reg)
            cnt_next = cnt_reg + 1'b1;
    end

    assign cnt_m1     = cnt_reg - 1'b1;
    assign sweep_addr = (cnt_reg < ENDC) ? cnt_reg[IDX_W-1:0] : '0;
    assign prune_addr = cnt_m1[IDX_W-1:0];

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            fadt_pkg::ST_INIT:
            begin
                cmd.clear_seen  = 1'b1;
                cmd.clear_valid = 1'b1;
            end
            fadt_pkg::ST_IDLE:
            begin
                in_stall           = 1'b0;
                cmd.load_in        = in_valid;
                cmd.clear_counters = in_valid && stat.op == fadt_pkg::OP_START;
            end
            fadt_pkg::ST_READ:    ;
            fadt_pkg::ST_EVAL:    cmd.commit = stat.out_free;
            fadt_pkg::ST_CLEAR:   cmd.clear_seen = 1'b1;
            fadt_pkg::ST_PRUNE:
            begin
                cmd.prune_rd = 1'b1;
                cmd.prune_wr = cnt_reg != '0;
            end
            fadt_pkg::ST_SUMMARY: cmd.emit_sum = stat.out_free;
            default:              ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fadt_pkg::ST_INIT;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= ENDC)
        else $error("sweep counter past end");

    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.commit, cmd.clear_seen, cmd.prune_wr, cmd.emit_sum}))
        else $error("two memory actions at once");

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit || cmd.emit_sum) |-> stat.out_free)
        else $error("result issued into busy output");

    a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fadt_pkg::ST_READ) |=> (state_reg == fadt_pkg::ST_EVAL))
        else $error("read step not followed by evaluation");

endmodule

`default_nettype wire

// ----- hdl/fadt_dp.sv -----
// fadt_dp: tracker memories, age and delta arithmetic, pass counters, output register
// depends on fadt_pkg
`default_nettype none

module fadt_dp #(
    parameter int FLOW_SLOTS = fadt_pkg::FLOW_SLOTS_DEF,
    parameter int IDX_W      = $clog2(FLOW_SLOTS)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [23:0]         cfg_data,
    input  wire fadt_pkg::in_item_t  in_data,
    input  wire logic                out_stall,
    output logic                     out_valid,
    output fadt_pkg::out_item_t      out_data,
    input  wire fadt_pkg::cmd_t      cmd,
    input  wire logic [IDX_W-1:0]    sweep_addr,
    input  wire logic [IDX_W-1:0]    prune_addr,
    output fadt_pkg::stat_t          stat
);

    logic [fadt_pkg::TO_W-1:0] tcp_to_reg, udp_to_reg, icmp_to_reg, gen_to_reg;

    fadt_pkg::in_item_t in_reg;
    logic [63:0] age_reg, age_next;
    logic [fadt_pkg::LIMIT_W-1:0] limit_reg, limit_next;
    logic [fadt_pkg::TO_W-1:0] to_sel;

    logic valid_mem [FLOW_SLOTS];
    logic seen_mem  [FLOW_SLOTS];
    fadt_pkg::prev_t prev_mem [FLOW_SLOTS];
    logic valid_rd, seen_rd;
    fadt_pkg::prev_t prev_rd;

    logic [IDX_W-1:0] slot_idx, rd_addr, valid_wa, seen_wa;
    logic valid_we, valid_wd, seen_we, seen_wd;

    logic [31:0] act_reg, exp_reg, walk_reg;
    logic [31:0] act_next, exp_next, walk_next;

    fadt_pkg::out_item_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;

    logic had, changed, expired, emit_rec;
    logic [62:0] p0, b0, dp, db;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcp_to_reg  <= fadt_pkg::TCP_TO_RST;
            udp_to_reg  <= fadt_pkg::UDP_TO_RST;
            icmp_to_reg <= fadt_pkg::ICMP_TO_RST;
            gen_to_reg  <= fadt_pkg::GEN_TO_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                fadt_pkg::REG_TCP_TO:  tcp_to_reg  <= cfg_data;
                fadt_pkg::REG_UDP_TO:  udp_to_reg  <= cfg_data;
                fadt_pkg::REG_ICMP_TO: icmp_to_reg <= cfg_data;
                fadt_pkg::REG_GEN_TO:  gen_to_reg  <= cfg_data;
                default:               ;
            endcase
        end
    end

    assign stat.op       = in_data.opcode;
    assign stat.slot_ok  = 32'(in_data.flow_slot) < 32'(FLOW_SLOTS);
    assign stat.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            in_reg <= in_data;
        age_reg   <= age_next;
        limit_reg <= limit_next;
    end

    always_comb
    begin
        case (in_reg.protocol) inside
            fadt_pkg::PROTO_TCP:                      to_sel = tcp_to_reg;
            fadt_pkg::PROTO_UDP:                      to_sel = udp_to_reg;
            fadt_pkg::PROTO_ICMP, fadt_pkg::PROTO_ICMP6: to_sel = icmp_to_reg;
            default:                                  to_sel = gen_to_reg;
        endcase
    end

    // timeout in ns, and age saturating at zero
    assign limit_next = fadt_pkg::LIMIT_W'(to_sel) * fadt_pkg::LIMIT_W'(fadt_pkg::NS_PER_S);
    assign age_next   = (in_reg.pass_time_ns >= in_reg.last_seen_ns) ?
                        in_reg.pass_time_ns - in_reg.last_seen_ns : 64'd0;

    assign slot_idx = IDX_W'(in_reg.flow_slot);
    assign rd_addr  = cmd.prune_rd ? sweep_addr : slot_idx;

    // memory write port selection
    always_comb
    begin
        valid_we = 1'b0;
        valid_wa = slot_idx;
        valid_wd = 1'b0;
        seen_we  = 1'b0;
        seen_wa  = slot_idx;
        seen_wd  = 1'b0;
        if (cmd.clear_seen)
        begin
            seen_we  = 1'b1;
            seen_wa  = sweep_addr;
            valid_we = cmd.clear_valid;
            valid_wa = sweep_addr;
        end
        else if (cmd.prune_wr)
        begin
            valid_we = 1'b1;
            valid_wa = prune_addr;
            valid_wd = valid_rd && seen_rd;
        end
        else if (cmd.commit)
        begin
            valid_we = 1'b1;
            valid_wd = !expired;
            seen_we  = 1'b1;
            seen_wd  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_we)
            valid_mem[valid_wa] <= valid_wd;
        valid_rd <= valid_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (seen_we)
            seen_mem[seen_wa] <= seen_wd;
        seen_rd <= seen_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            prev_mem[slot_idx] <= '{pk: in_reg.packet_count, by: in_reg.byte_count,
                                    ls: in_reg.last_seen_ns};
        prev_rd <= prev_mem[rd_addr];
    end

    // record evaluation
    assign had     = valid_rd;
    assign p0      = had ? prev_rd.pk : 63'd0;
    assign b0      = had ? prev_rd.by : 63'd0;
    assign dp      = (in_reg.packet_count >= p0) ? in_reg.packet_count - p0 : in_reg.packet_count;
    assign db      = (in_reg.byte_count >= b0) ? in_reg.byte_count - b0 : in_reg.byte_count;
    assign changed = !had || in_reg.last_seen_ns != prev_rd.ls ||
                     in_reg.packet_count != prev_rd.pk || in_reg.byte_count != prev_rd.by;
    assign expired = age_reg > {{(64 - fadt_pkg::LIMIT_W){1'b0}}, limit_reg};
    assign emit_rec = cmd.commit && (expired || changed);

    // saturating pass counters
    always_comb
    begin
        act_next  = act_reg;
        exp_next  = exp_reg;
        walk_next = walk_reg;
        if (cmd.clear_counters)
        begin
            act_next  = '0;
            exp_next  = '0;
            walk_next = '0;
        end
        else if (cmd.commit)
        begin
            walk_next = (walk_reg == '1) ? walk_reg : walk_reg + 1'b1;
            if (expired)
                exp_next = (exp_reg == '1) ? exp_reg : exp_reg + 1'b1;
            else
                act_next = (act_reg == '1) ? act_reg : act_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg  <= '0;
            exp_reg  <= '0;
            walk_reg <= '0;
        end
        else
        begin
            act_reg  <= act_next;
            exp_reg  <= exp_next;
            walk_reg <= walk_next;
        end
    end

    // output register
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (emit_rec)
        begin
            out_next                  = '0;
            out_next.kind             = expired ? fadt_pkg::KIND_EXPIRED : fadt_pkg::KIND_ACTIVE;
            out_next.out_slot         = in_reg.flow_slot;
            out_next.out_protocol     = in_reg.protocol;
            out_next.out_packets      = in_reg.packet_count;
            out_next.out_bytes        = in_reg.byte_count;
            out_next.out_last_seen_ns = in_reg.last_seen_ns;
            out_next.delta_packets    = dp;
            out_next.delta_bytes      = db;
            out_valid_next            = 1'b1;
        end
        else if (cmd.emit_sum)
        begin
            out_next               = '0;
            out_next.kind          = fadt_pkg::KIND_SUMMARY;
            out_next.active_total  = act_reg;
            out_next.expired_total = exp_reg;
            out_next.walked_total  = walk_reg;
            out_valid_next         = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// ----- test/tb_flow_aging_delta_tracker.sv -----
// testbench of flow_aging_delta_tracker: random and directed flow records, pass
// start/end beats and timeout writes, checked beat by beat against a scoreboard
// depends on fadt_pkg and the flow_aging_delta_tracker rtl
`default_nettype none

module tb_flow_aging_delta_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 1024;
    localparam logic [31:0] SAT = 32'hFFFF_FFFF;

    // tracker model used to predict every output beat
    class aging_scoreboard;
        bit          valid_q [SLOTS];
        bit          seen_q  [SLOTS];
        logic [62:0] pk_q    [SLOTS];
        logic [62:0] by_q    [SLOTS];
        logic [63:0] ls_q    [SLOTS];
        logic [31:0] n_active, n_expired, n_walked;
        logic [23:0] timeout_s [4];
        fadt_pkg::out_item_t pending [$];
        int          errors;
        int          reported;
        int          n_checked;

        function void init();
            for (int i = 0; i < SLOTS; i++)
            begin
                valid_q[i] = 0;
                seen_q[i]  = 0;
            end
            n_active = 0;
            n_expired = 0;
            n_walked = 0;
            timeout_s[fadt_pkg::REG_TCP_TO]  = fadt_pkg::TCP_TO_RST;
            timeout_s[fadt_pkg::REG_UDP_TO]  = fadt_pkg::UDP_TO_RST;
            timeout_s[fadt_pkg::REG_ICMP_TO] = fadt_pkg::ICMP_TO_RST;
            timeout_s[fadt_pkg::REG_GEN_TO]  = fadt_pkg::GEN_TO_RST;
            errors = 0;
            reported = 0;
            n_checked = 0;
        endfunction

        function void write_timeout(fadt_pkg::reg_idx_t idx, logic [23:0] val);
            timeout_s[idx] = val;
        endfunction

        function logic [31:0] bump(logic [31:0] c);
            return (c == SAT) ? SAT : c + 32'd1;
        endfunction

        // note an accepted input beat and queue its result, if any
        function void note_input(fadt_pkg::in_item_t it);
            fadt_pkg::out_item_t r;
            logic [63:0] age;
            logic [62:0] p0, b0;
            logic [23:0] to;
            logic [63:0] limit;
            bit          had, changed, expired;
            int          s;
            r = '0;
            case (fadt_pkg::op_t'(it.opcode))
                fadt_pkg::OP_START:
                begin
                    for (int i = 0; i < SLOTS; i++)
                        seen_q[i] = 0;
                    n_active = 0;
                    n_expired = 0;
                    n_walked = 0;
                end
                fadt_pkg::OP_END:
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (valid_q[i] && !seen_q[i])
                            valid_q[i] = 0;
                    r.kind = fadt_pkg::KIND_SUMMARY;
                    r.active_total = n_active;
                    r.expired_total = n_expired;
                    r.walked_total = n_walked;
                    pending.push_back(r);
                end
                fadt_pkg::OP_RECORD:
                begin
                    s = int'(it.flow_slot);
                    age = (it.pass_time_ns >= it.last_seen_ns) ?
                          it.pass_time_ns - it.last_seen_ns : 64'd0;
                    had = valid_q[s];
                    p0 = had ? pk_q[s] : 63'd0;
                    b0 = had ? by_q[s] : 63'd0;
                    changed = !had || it.last_seen_ns != ls_q[s] ||
                              it.packet_count != pk_q[s] || it.byte_count != by_q[s];
                    seen_q[s] = 1;
                    valid_q[s] = 1;
                    pk_q[s] = it.packet_count;
                    by_q[s] = it.byte_count;
                    ls_q[s] = it.last_seen_ns;
                    if (it.protocol == fadt_pkg::PROTO_TCP)
                        to = timeout_s[fadt_pkg::REG_TCP_TO];
                    else if (it.protocol == fadt_pkg::PROTO_UDP)
                        to = timeout_s[fadt_pkg::REG_UDP_TO];
                    else if (it.protocol == fadt_pkg::PROTO_ICMP ||
                             it.protocol == fadt_pkg::PROTO_ICMP6)
                        to = timeout_s[fadt_pkg::REG_ICMP_TO];
                    else
                        to = timeout_s[fadt_pkg::REG_GEN_TO];
                    limit = 64'(to) * 64'd1000000000;
                    expired = age > limit;
                    r.out_slot = it.flow_slot;
                    r.out_protocol = it.protocol;
                    r.out_packets = it.packet_count;
                    r.out_bytes = it.byte_count;
                    r.out_last_seen_ns = it.last_seen_ns;
                    r.delta_packets = (it.packet_count >= p0) ?
                                      it.packet_count - p0 : it.packet_count;
                    r.delta_bytes = (it.byte_count >= b0) ?
                                    it.byte_count - b0 : it.byte_count;
                    n_walked = bump(n_walked);
                    if (expired)
                    begin
                        valid_q[s] = 0;
                        n_expired = bump(n_expired);
                        r.kind = fadt_pkg::KIND_EXPIRED;
                        pending.push_back(r);
                    end
                    else
                    begin
                        n_active = bump(n_active);
                        if (changed)
                        begin
                            r.kind = fadt_pkg::KIND_ACTIVE;
                            pending.push_back(r);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void flag(string what, fadt_pkg::out_item_t exp_r,
                           fadt_pkg::out_item_t got);
            errors++;
            if (reported < 10)
            begin
                reported++;
                $display("mismatch %s: expected %p", what, exp_r);
                $display("           actual   %p", got);
            end
        endfunction

        // compare one output beat with the oldest expectation
        function void check_result(fadt_pkg::out_item_t got);
            fadt_pkg::out_item_t e;
            if (pending.size() == 0)
            begin
                flag("unexpected beat", '0, got);
                return;
            end
            e = pending.pop_front();
            n_checked++;
            if (got.kind !== e.kind || got.out_slot !== e.out_slot ||
                got.out_protocol !== e.out_protocol ||
                got.out_packets !== e.out_packets || got.out_bytes !== e.out_bytes ||
                got.out_last_seen_ns !== e.out_last_seen_ns ||
                got.delta_packets !== e.delta_packets ||
                got.delta_bytes !== e.delta_bytes ||
                got.active_total !== e.active_total ||
                got.expired_total !== e.expired_total ||
                got.walked_total !== e.walked_total)
                flag("field", e, got);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    fadt_pkg::in_item_t  in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    fadt_pkg::out_item_t out_data;

    aging_scoreboard sb;

    // idle percentages for each side, changed per phase
    int sender_idle_pct = 0;
    int stall_pct = 0;
    int hold_off_cycles = 0;
    int n_sent = 0;

    always #1 clk = ~clk;

    flow_aging_delta_tracker u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // receiver: random stall, plus a long hold-off when requested
    always @(posedge clk)
    begin
        if (out_valid && !out_stall && rst_n)
            sb.check_result(out_data);
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // send one beat, with a random gap first; the beat is held until accepted
    // valid is dropped by the next gap or by drain
    task automatic send_beat(fadt_pkg::in_item_t it);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(it);
        n_sent++;
    endtask

    function automatic fadt_pkg::in_item_t make_record(int slot, logic [7:0] proto,
                                                       logic [62:0] pk, logic [62:0] by,
                                                       logic [63:0] ls, logic [63:0] now);
        fadt_pkg::in_item_t it;
        it.opcode = fadt_pkg::OP_RECORD;
        it.flow_slot = 10'(slot);
        it.protocol = proto;
        it.packet_count = pk;
        it.byte_count = by;
        it.last_seen_ns = ls;
        it.pass_time_ns = now;
        return it;
    endfunction

    function automatic fadt_pkg::in_item_t make_op(fadt_pkg::op_t op);
        fadt_pkg::in_item_t it;
        it = '0;
        it.opcode = op;
        // random payload on control beats, which the block ignores
        it.flow_slot = 10'($urandom);
        it.protocol = 8'($urandom);
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // wait until every expected beat has come, then a margin for background work
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (2 * SLOTS + 20) @(posedge clk);
    endtask

    // one write beat, with cfg_wr_en low again before the next one
    task automatic write_reg(fadt_pkg::reg_idx_t idx, logic [23:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.write_timeout(idx, val);
        @(posedge clk);
    endtask

    // random record: slot from a small pool to hit repeats of a slot
    function automatic fadt_pkg::in_item_t rand_record(int pool, logic [63:0] now);
        logic [7:0]  proto;
        logic [63:0] ls;
        int          pick;
        pick = $urandom_range(5);
        case (pick)
            0: proto = fadt_pkg::PROTO_TCP;
            1: proto = fadt_pkg::PROTO_UDP;
            2: proto = fadt_pkg::PROTO_ICMP;
            3: proto = fadt_pkg::PROTO_ICMP6;
            default: proto = 8'($urandom);
        endcase
        case ($urandom_range(3))
            0: ls = now - 64'($urandom_range(400)) * 64'd1000000000;
            1: ls = now + 64'($urandom_range(1000));
            2: ls = rand64();
            default: ls = now - 64'($urandom);
        endcase
        return make_record(int'($urandom_range(pool - 1)), proto,
                           ($urandom_range(3) == 0) ? 63'(rand64()) : 63'($urandom_range(50)),
                           ($urandom_range(3) == 0) ? 63'(rand64()) : 63'($urandom),
                           ls, now);
    endfunction

    // one well-formed pass: start, records with an occasional none beat, end
    task automatic run_pass(int n_rec, int pool);
        logic [63:0] now;
        now = rand64();
        send_beat(make_op(fadt_pkg::OP_START));
        for (int i = 0; i < n_rec; i++)
        begin
            if ($urandom_range(19) == 0)
                send_beat(make_op(fadt_pkg::OP_NONE));
            send_beat(rand_record(pool, now));
        end
        send_beat(make_op(fadt_pkg::OP_END));
    endtask

    initial
    begin
        logic [63:0] t0;
        sb = new();
        sb.init();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        // wait out the clearing pass after reset
        @(posedge clk);
        while (in_stall)
            @(posedge clk);

        // directed: reset timeouts, extremes, all opcodes and special cases
        t0 = 64'd1_000_000_000_000;
        send_beat(make_op(fadt_pkg::OP_END));                 // end without start
        send_beat(make_op(fadt_pkg::OP_START));
        send_beat(make_record(0, fadt_pkg::PROTO_TCP, '0, '0, t0, t0));
        send_beat(make_record(0, fadt_pkg::PROTO_TCP, '0, '0, t0, t0)); // unchanged
        send_beat(make_record(0, fadt_pkg::PROTO_TCP, '1, '1, t0, t0));
        send_beat(make_record(0, fadt_pkg::PROTO_TCP, 63'd5, 63'd7, t0, t0)); // fell
        send_beat(make_record(SLOTS - 1, fadt_pkg::PROTO_UDP, '1, '1, '1, '0)); // future
        send_beat(make_record(1, fadt_pkg::PROTO_UDP, 63'd1, 63'd1,
                              t0 - 64'd180_000_000_000, t0));
        send_beat(make_record(2, fadt_pkg::PROTO_UDP, 63'd1, 63'd1,
                              t0 - 64'd180_000_000_001, t0));
        send_beat(make_record(3, fadt_pkg::PROTO_ICMP, 63'd1, 63'd1,
                              t0 - 64'd31_000_000_000, t0));
        send_beat(make_record(4, fadt_pkg::PROTO_ICMP6, 63'd1, 63'd1,
                              t0 - 64'd29_000_000_000, t0));
        send_beat(make_record(5, 8'd255, 63'd1, 63'd1, t0 - 64'd601_000_000_000, t0));
        send_beat(make_record(6, 8'd0, 63'd1, 63'd1, '0, '1));     // huge age
        send_beat(make_op(fadt_pkg::OP_NONE));
        send_beat(make_op(fadt_pkg::OP_END));
        send_beat(make_op(fadt_pkg::OP_START));
        send_beat(make_record(1, fadt_pkg::PROTO_UDP, 63'd2, 63'd2, t0, t0));
        send_beat(make_op(fadt_pkg::OP_END));                 // prunes unseen slots
        drain();

        // zero timeouts: anything with positive age expires
        write_reg(fadt_pkg::REG_TCP_TO, 24'd0);
        write_reg(fadt_pkg::REG_UDP_TO, 24'd0);
        write_reg(fadt_pkg::REG_ICMP_TO, 24'd0);
        write_reg(fadt_pkg::REG_GEN_TO, 24'd0);
        send_beat(make_op(fadt_pkg::OP_START));
        send_beat(make_record(7, fadt_pkg::PROTO_TCP, 63'd1, 63'd1, t0, t0));
        send_beat(make_record(8, fadt_pkg::PROTO_TCP, 63'd1, 63'd1, t0 - 64'd1, t0));
        send_beat(make_op(fadt_pkg::OP_END));
        drain();

        // random phases with differing idling and timeout settings
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 67; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 67; end
                default: begin sender_idle_pct = 28; stall_pct = 28; end
            endcase
            if (ph == 7)
            begin
                write_reg(fadt_pkg::REG_TCP_TO, 24'hFFFFFF);
                write_reg(fadt_pkg::REG_UDP_TO, 24'hFFFFFF);
                write_reg(fadt_pkg::REG_ICMP_TO, 24'hFFFFFF);
                write_reg(fadt_pkg::REG_GEN_TO, 24'hFFFFFF);
            end
            else
            begin
                write_reg(fadt_pkg::REG_TCP_TO, 24'($urandom_range(400)));
                write_reg(fadt_pkg::REG_UDP_TO, 24'($urandom_range(400)));
                write_reg(fadt_pkg::REG_ICMP_TO, 24'($urandom_range(400)));
                write_reg(fadt_pkg::REG_GEN_TO, 24'($urandom));
            end
            // receiver backs up while records flow; outlasts the pass start sweep
            if (ph == 4)
                hold_off_cycles = 1500;
            for (int p = 0; p < 2; p++)
                run_pass(25, (ph % 2) ? 4 : 64);
            if ($urandom_range(1))
                send_beat(make_record(SLOTS - 1, 8'($urandom), 63'(rand64()),
                                      63'(rand64()), rand64(), rand64()));
            drain();
        end
        sender_idle_pct = 0;
        stall_pct = 0;
        $display("covered %0d input beats and %0d checked results over several",
                 n_sent, sb.n_checked);
        $display("timeout settings, idle patterns and a long receiver hold-off");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS flow_aging_delta_tracker");
        else
            $display("FAIL flow_aging_delta_tracker");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL flow_aging_delta_tracker");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
hdl/fadt_pkg.sv
hdl/fadt_ctrl.sv
hdl/fadt_dp.sv
hdl/flow_aging_delta_tracker.sv
test/tb_flow_aging_delta_tracker.sv
